>>> sv/svmdc_pkg.sv
package svmdc_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int ANGLE_FRAC_BITS = 6;

	localparam logic [15:0] Q15_ONE = 16'd32768;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] PI_OVER_3_Q30 = 64'd1124419809;
	localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
	localparam logic [16:0] SQRT3_Q16 = 17'd113512;
	localparam logic [15:0] ATTEN_RESET = 16'd32768;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_DC_LINK = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ATTEN = 2'd1;

	typedef struct packed {
		logic [2:0] sec;
		logic       fault;
		logic       limited;
	} side_t;

	typedef struct packed {
		logic [32:0] num;
		logic [15:0] rem;
		logic [16:0] quo;
		logic        ovf;
	} div_t;

	// odd taylor series to x^9, q30 angle in, q15 sine out
	function automatic logic [15:0] sine_from_x(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] r;
		x2 = (x * x) >> 30;
		t = Q30_ONE - x2 / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		r = (((x * t) >> 30) + 64'd16384) >> 15;
		return r[15:0];
	endfunction

endpackage

>>> sv/svm_duty_cycle_calc_unit.sv
// space vector pwm duty calculation, two-level inverter
// input channel: in_valid / in_stall with ref_magnitude (1/256 V) and
// ref_angle (signed, 1/2^ANGLE_FRAC_BITS degree, valid 0 to below 360 deg)
// output channel: out_valid / out_stall with the three Q1.15 phase duties,
// sector (0..5), sector_fault and limited
// a transaction happens on an edge where valid is high and stall is low
// configuration: wr_en, wr_index, wr_data; index 0 is dc_link_voltage,
// index 1 is attenuation, other indexes are ignored
// a new item is taken every cycle while out_stall does not hold a
// waiting result; the pipeline is built of constant multipliers, the
// sine rom read and two 17-stage restoring dividers (one quotient bit
// per stage)
// when out_stall holds a waiting result the whole pipeline freezes and
// in_stall rises; nothing is dropped or repeated
// reset empties the pipeline, sets dc_link_voltage to 0 and attenuation
// to 1.0
module svm_duty_cycle_calc_unit #(
	parameter int SINE_TABLE_DEPTH = svmdc_pkg::SINE_TABLE_DEPTH,
	parameter int ANGLE_FRAC_BITS = svmdc_pkg::ANGLE_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [svmdc_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [15:0]                    wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    ref_magnitude,
	input  logic signed [15:0]             ref_angle,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [15:0]                    duty_phase_a,
	output logic [15:0]                    duty_phase_b,
	output logic [15:0]                    duty_phase_c,
	output logic [2:0]                     sector,
	output logic                           sector_fault,
	output logic                           limited
);

	localparam int SPAN = 60 << ANGLE_FRAC_BITS;
	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int RW = $clog2(SPAN);
	localparam int NDIV = 17;
	// reciprocal of the sector span scaled by the table depth
	localparam int RK = 2 * $clog2(SPAN + 1);
	localparam longint unsigned RMD =
		((64'(SINE_TABLE_DEPTH) << RK) + 64'(SPAN) - 64'd1) / 64'(SPAN);
	localparam int NW = RW + 1;
	localparam int MW = $clog2(RMD + 64'd1);

	logic [15:0] dc_q;
	logic [15:0] att_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
			att_q <= svmdc_pkg::ATTEN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				svmdc_pkg::REG_DC_LINK: dc_q <= wr_data;
				svmdc_pkg::REG_ATTEN: att_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [63:0] X =
			(64'(gi) * svmdc_pkg::PI_OVER_3_Q30) / 64'(SINE_TABLE_DEPTH);
		assign sine_rom[gi] = svmdc_pkg::sine_from_x(X);
	end

	// valid bits: s1..s6, divider stages 0..NDIV, final time stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_ft;
	logic [NDIV:0] v_dv;

	logic [15:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [15:0] ang_s1;
	logic [31:0] dcatt_s1, dcatt_s2;
	logic [2:0]  sec_s2, sec_s3;
	logic        fault_s2, fault_s3;
	logic [RW-1:0] rel_s2;
	logic [IW-1:0] idx1_s3, idx2_s3;
	logic [16:0] limit_s3;
	logic [15:0] sin1_s4, sin2_s4;
	svmdc_pkg::side_t side_s4, side_s5, side_s6, side_ft;
	logic [31:0] m1_s5, m2_s5;
	logic [32:0] n1_s6, n2_s6;
	svmdc_pkg::div_t dv1_s [NDIV+1];
	svmdc_pkg::div_t dv2_s [NDIV+1];
	svmdc_pkg::side_t dvside_s [NDIV+1];
	logic [15:0] t1_ft, t2_ft;

	logic [31:0] ang_u;
	logic [2:0]  sec_c;
	logic [NW+MW-1:0] idx1_prod, idx2_prod;
	logic [47:0] lim_prod;
	logic [15:0] magc;
	logic [48:0] n1_full, n2_full;

	assign ang_u = 32'(ang_s1);

	// sector by comparison against the span boundaries
	always_comb begin
		sec_c = '0;
		for (int k = 1; k < 6; k++) begin
			if (ang_u >= 32'(k * SPAN))
				sec_c = 3'(k);
		end
	end

	assign idx1_prod = (NW+MW)'(NW'(SPAN) - NW'(rel_s2)) * (NW+MW)'(RMD);
	assign idx2_prod = (NW+MW)'(rel_s2) * (NW+MW)'(RMD);
	assign lim_prod = 48'(dcatt_s2) * 48'(svmdc_pkg::INV_SQRT3_Q16);
	assign magc = (17'(mag_s3) > limit_s3) ? limit_s3[15:0] : mag_s3;
	assign n1_full = 49'(m1_s5) * 49'(svmdc_pkg::SQRT3_Q16);
	assign n2_full = 49'(m2_s5) * 49'(svmdc_pkg::SQRT3_Q16);

	function automatic svmdc_pkg::div_t div_init(input logic [32:0] n, input logic [15:0] d);
		svmdc_pkg::div_t r;
		r.num = n;
		r.rem = n[32:17];
		r.quo = '0;
		r.ovf = n >= {d, 17'd0};
		return r;
	endfunction

	function automatic svmdc_pkg::div_t div_step(input svmdc_pkg::div_t a,
			input logic [15:0] d, input int bitpos);
		svmdc_pkg::div_t r;
		logic [16:0] t;
		logic        ge;
		r = a;
		t = {a.rem, a.num[bitpos]};
		ge = t >= {1'b0, d};
		r.rem = ge ? 16'(t - {1'b0, d}) : t[15:0];
		r.quo[bitpos] = ge;
		return r;
	endfunction

	function automatic logic [15:0] div_final(input svmdc_pkg::div_t a, input logic [15:0] d);
		logic [15:0] r;
		if (d == '0) begin
			r = '0;
		end else if (a.ovf || a.quo > 17'(svmdc_pkg::Q15_ONE)) begin
			r = svmdc_pkg::Q15_ONE;
		end else begin
			r = a.quo[15:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_dv <= '0;
			v_ft <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_dv <= {v_dv[NDIV-1:0], v_s6};
			v_ft <= v_dv[NDIV];
			out_valid <= v_ft;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= ref_magnitude;
			ang_s1 <= ref_angle;
			dcatt_s1 <= 32'(dc_q) * 32'(att_q);

			mag_s2 <= mag_s1;
			dcatt_s2 <= dcatt_s1;
			fault_s2 <= ang_s1[15] || (ang_u >= 32'(6 * SPAN));
			sec_s2 <= sec_c;
			rel_s2 <= RW'(ang_u - 32'(sec_c) * 32'(SPAN));

			mag_s3 <= mag_s2;
			sec_s3 <= sec_s2;
			fault_s3 <= fault_s2;
			idx1_s3 <= IW'(idx1_prod >> RK);
			idx2_s3 <= IW'(idx2_prod >> RK);
			limit_s3 <= lim_prod[47:31];

			sin1_s4 <= sine_rom[idx1_s3];
			sin2_s4 <= sine_rom[idx2_s3];
			mag_s4 <= magc;
			side_s4.sec <= sec_s3;
			side_s4.fault <= fault_s3;
			side_s4.limited <= 17'(mag_s3) > limit_s3;

			m1_s5 <= 32'(mag_s4) * 32'(sin1_s4);
			m2_s5 <= 32'(mag_s4) * 32'(sin2_s4);
			side_s5 <= side_s4;

			n1_s6 <= n1_full[48:16];
			n2_s6 <= n2_full[48:16];
			side_s6 <= side_s5;

			dv1_s[0] <= div_init(n1_s6, dc_q);
			dv2_s[0] <= div_init(n2_s6, dc_q);
			dvside_s[0] <= side_s6;
			for (int k = 0; k < NDIV; k++) begin
				dv1_s[k+1] <= div_step(dv1_s[k], dc_q, NDIV - 1 - k);
				dv2_s[k+1] <= div_step(dv2_s[k], dc_q, NDIV - 1 - k);
				dvside_s[k+1] <= dvside_s[k];
			end

			t1_ft <= div_final(dv1_s[NDIV], dc_q);
			t2_ft <= div_final(dv2_s[NDIV], dc_q);
			side_ft <= dvside_s[NDIV];
		end
	end

	logic [16:0] sum;
	logic [17:0] tmin, tmed, tmax;
	logic [17:0] da, db, dcv;

	function automatic logic [15:0] sat_duty(input logic [17:0] v);
		return (v > 18'(svmdc_pkg::Q15_ONE)) ? svmdc_pkg::Q15_ONE : v[15:0];
	endfunction

	always_comb begin
		sum = 17'(t1_ft) + 17'(t2_ft);
		tmin = (sum >= 17'(svmdc_pkg::Q15_ONE)) ? '0 :
			18'((17'(svmdc_pkg::Q15_ONE) - sum) >> 1);
		if (!side_ft.sec[0]) begin
			tmed = tmin + 18'(t2_ft);
			tmax = tmed + 18'(t1_ft);
		end else begin
			tmed = tmin + 18'(t1_ft);
			tmax = tmed + 18'(t2_ft);
		end
		case (side_ft.sec)
			3'd0: begin da = tmax; db = tmed; dcv = tmin; end
			3'd1: begin da = tmed; db = tmax; dcv = tmin; end
			3'd2: begin da = tmin; db = tmax; dcv = tmed; end
			3'd3: begin da = tmin; db = tmed; dcv = tmax; end
			3'd4: begin da = tmed; db = tmin; dcv = tmax; end
			default: begin da = tmax; db = tmin; dcv = tmed; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			limited <= side_ft.limited;
			sector_fault <= side_ft.fault;
			if (side_ft.fault) begin
				duty_phase_a <= '0;
				duty_phase_b <= '0;
				duty_phase_c <= '0;
				sector <= '0;
			end else begin
				duty_phase_a <= sat_duty(da);
				duty_phase_b <= sat_duty(db);
				duty_phase_c <= sat_duty(dcv);
				sector <= side_ft.sec;
			end
		end
	end

endmodule
